@@ design/dcc_pkg.sv @@
// Shared types and constants for the DMA channel controller.
// No dependencies; used by every module of the block.
package dcc_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int CH_W = 2;
    localparam int CNT_W = 17;
    localparam int Q_DEPTH = 2;

    localparam logic [2:0] FUNC_PROGRAM = 3'd0;
    localparam logic [2:0] FUNC_TRIGGER = 3'd1;
    localparam logic [2:0] FUNC_STOP    = 3'd2;
    localparam logic [2:0] FUNC_ADVANCE = 3'd3;

    localparam logic [1:0] PMODE_INC    = 2'd0;
    localparam logic [1:0] PMODE_DEC    = 2'd1;
    localparam logic [1:0] PMODE_RELOAD = 2'd3;

    localparam int M_DEST_LO = 5;
    localparam int M_SRC_LO  = 7;
    localparam int M_REPEAT  = 9;
    localparam int M_WIDE    = 10;
    localparam int M_DREQ    = 11;
    localparam int M_TIM_LO  = 12;
    localparam int M_ENABLE  = 15;

    typedef struct packed {
        logic [2:0]  func;
        logic [1:0]  channel;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [31:0] control_word;
        logic [1:0]  start_type;
    } t_cmd;

    typedef struct packed {
        logic                    transfer_valid;
        logic [31:0]             read_addr;
        logic [31:0]             write_addr;
        logic                    wide;
        logic [1:0]              xfer_channel;
        logic                    last;
        logic [NUM_CHANNELS-1:0] busy_mask;
    } t_res;

endpackage

@@ design/dcc_front.sv @@
// Front end: accepts commands into a short queue ahead of the engine.
// Depends on dcc_pkg.
module dcc_front import dcc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  t_cmd i_cmd,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_take
);
    t_cmd       r_mem [Q_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_full = (r_cnt == 2'(Q_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd = r_mem[r_rp];
    assign w_push = i_push && !o_full;
    assign w_pop = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

@@ design/dcc_engine.sv @@
// Back end: channel state, priority pick and pointer stepping, with a result queue.
// Depends on dcc_pkg.
module dcc_engine import dcc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_cmd i_cmd,
    output logic o_take,
    output logic o_empty,
    output t_res o_res,
    input  logic i_pop
);
    logic [31:0]      r_src [NUM_CHANNELS];
    logic [31:0]      r_dst [NUM_CHANNELS];
    logic [31:0]      r_sav [NUM_CHANNELS];
    logic [CNT_W-1:0] r_cnt [NUM_CHANNELS];
    logic [CNT_W-1:0] r_left [NUM_CHANNELS];
    logic [15:0]      r_mode [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_armed;

    logic [31:0]      n_src [NUM_CHANNELS];
    logic [31:0]      n_dst [NUM_CHANNELS];
    logic [15:0]      n_mode [NUM_CHANNELS];
    logic [CNT_W-1:0] n_left [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] n_armed;

    t_res       r_q [Q_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_qn;
    logic       w_fire, w_pop;
    t_res       w_res;
    logic       w_found;
    logic [CH_W-1:0] w_sel;
    logic [31:0] w_size;
    logic [1:0]  w_sm;
    logic        w_fin;

    assign o_take = i_valid && (r_qn != 2'(Q_DEPTH));
    assign w_fire = o_take;
    assign o_empty = (r_qn == 2'd0);
    assign o_res = r_q[r_rp];
    assign w_pop = i_pop && !o_empty;

    always_comb begin
        w_found = 1'b0;
        w_sel = '0;
        for (int c = NUM_CHANNELS - 1; c >= 0; c--) begin
            if (r_armed[c]) begin
                w_found = 1'b1;
                w_sel = CH_W'(c);
            end
        end
        w_size = r_mode[w_sel][M_WIDE] ? 32'd4 : 32'd2;
        w_fin = (r_left[w_sel] <= CNT_W'(1));
        w_sm = r_mode[w_sel][M_SRC_LO +: 2];
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            n_src[c] = r_src[c];
            n_dst[c] = r_dst[c];
            n_mode[c] = r_mode[c];
            n_left[c] = r_left[c];
        end
        n_armed = r_armed;
        w_res = '0;
        case (i_cmd.func)
            FUNC_PROGRAM: begin
                n_src[i_cmd.channel] = i_cmd.src_addr;
                n_dst[i_cmd.channel] = i_cmd.dst_addr;
                n_mode[i_cmd.channel] = i_cmd.control_word[31:16];
                n_left[i_cmd.channel] = '0;
                n_armed[i_cmd.channel] = 1'b0;
                if (i_cmd.control_word[16 + M_ENABLE]
                    && i_cmd.control_word[16 + M_TIM_LO +: 2] == 2'b00) begin
                    if (i_cmd.control_word[CNT_W-1:0] != '0) begin
                        n_left[i_cmd.channel] = i_cmd.control_word[CNT_W-1:0];
                        n_armed[i_cmd.channel] = 1'b1;
                    end else if (!i_cmd.control_word[16 + M_REPEAT]) begin
                        n_mode[i_cmd.channel][M_ENABLE] = 1'b0;
                    end
                end
            end
            FUNC_TRIGGER: begin
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    if (!r_armed[c] && r_mode[c][M_ENABLE]
                        && r_mode[c][M_TIM_LO +: 2] == i_cmd.start_type) begin
                        if (r_cnt[c] == '0) begin
                            if (r_mode[c][M_REPEAT]) begin
                                if (r_mode[c][M_DEST_LO +: 2] == PMODE_RELOAD) begin
                                    n_dst[c] = r_sav[c];
                                end
                            end else begin
                                n_mode[c][M_ENABLE] = 1'b0;
                            end
                        end else begin
                            n_left[c] = r_cnt[c];
                            n_armed[c] = 1'b1;
                        end
                    end
                end
            end
            FUNC_STOP: begin
                n_mode[i_cmd.channel][M_ENABLE] = 1'b0;
                n_mode[i_cmd.channel][M_TIM_LO +: 2] = 2'b00;
                n_mode[i_cmd.channel][M_DREQ] = 1'b0;
                n_mode[i_cmd.channel][M_REPEAT] = 1'b0;
                n_armed[i_cmd.channel] = 1'b0;
            end
            FUNC_ADVANCE: begin
                if (w_found) begin
                    w_res.transfer_valid = 1'b1;
                    w_res.read_addr = r_src[w_sel];
                    w_res.write_addr = r_dst[w_sel];
                    w_res.wide = r_mode[w_sel][M_WIDE];
                    w_res.xfer_channel = w_sel;
                    w_res.last = w_fin;
                    case (r_mode[w_sel][M_DEST_LO +: 2])
                        PMODE_INC, PMODE_RELOAD: n_dst[w_sel] = r_dst[w_sel] + w_size;
                        PMODE_DEC: n_dst[w_sel] = r_dst[w_sel] - w_size;
                        default: n_dst[w_sel] = r_dst[w_sel];
                    endcase
                    case (w_sm)
                        PMODE_INC: n_src[w_sel] = r_src[w_sel] + w_size;
                        PMODE_DEC: n_src[w_sel] = r_src[w_sel] - w_size;
                        default: n_src[w_sel] = r_src[w_sel];
                    endcase
                    n_left[w_sel] = w_fin ? '0 : r_left[w_sel] - CNT_W'(1);
                    if (w_fin) begin
                        n_armed[w_sel] = 1'b0;
                        if (r_mode[w_sel][M_REPEAT]) begin
                            if (r_mode[w_sel][M_DEST_LO +: 2] == PMODE_RELOAD) begin
                                n_dst[w_sel] = r_sav[w_sel];
                            end
                        end else begin
                            n_mode[w_sel][M_ENABLE] = 1'b0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            w_res.busy_mask[c] = n_mode[c][M_ENABLE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_q[r_wp] <= w_res;
        end
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_src[c] <= '0;
                r_dst[c] <= '0;
                r_sav[c] <= '0;
                r_cnt[c] <= '0;
                r_left[c] <= '0;
                r_mode[c] <= '0;
            end
            r_armed <= '0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_qn <= 2'd0;
        end else begin
            if (w_fire) begin
                r_wp <= ~r_wp;
                if (i_cmd.func == FUNC_PROGRAM) begin
                    r_sav[i_cmd.channel] <= i_cmd.dst_addr;
                    r_cnt[i_cmd.channel] <= i_cmd.control_word[CNT_W-1:0];
                end
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    r_src[c] <= n_src[c];
                    r_dst[c] <= n_dst[c];
                    r_mode[c] <= n_mode[c];
                    r_left[c] <= n_left[c];
                end
                r_armed <= n_armed;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_qn <= r_qn + 2'(w_fire) - 2'(w_pop);
        end
    end
endmodule

@@ design/dma_channel_controller_core.sv @@
// Top level of the four-channel DMA controller.
// Depends on dcc_pkg, dcc_front and dcc_engine.
// Commands enter a two-entry queue and each one yields exactly one result item.
// The engine retires one command per cycle while the result queue has room, so
// the block sustains one item per cycle unless results are left unpopped; each
// item passes the command queue register, then the result queue register.
// Both queues hold two items.
module dma_channel_controller_core import dcc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_func,
    input  logic [1:0]  i_channel,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [31:0] i_control_word,
    input  logic [1:0]  i_start_type,
    output logic        empty,
    input  logic        pop,
    output logic        o_transfer_valid,
    output logic [31:0] o_read_addr,
    output logic [31:0] o_write_addr,
    output logic        o_wide,
    output logic [1:0]  o_xfer_channel,
    output logic        o_last,
    output logic [3:0]  o_busy_mask
);
    t_cmd w_in, w_cmd;
    t_res w_res;
    logic w_valid, w_take;

    assign w_in = '{func: i_func, channel: i_channel, src_addr: i_src_addr,
                    dst_addr: i_dst_addr, control_word: i_control_word,
                    start_type: i_start_type};

    dcc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_cmd(w_in), .o_valid(w_valid), .o_cmd(w_cmd), .i_take(w_take)
    );

    dcc_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_valid), .i_cmd(w_cmd),
        .o_take(w_take), .o_empty(empty), .o_res(w_res), .i_pop(pop)
    );

    assign o_transfer_valid = w_res.transfer_valid;
    assign o_read_addr = w_res.read_addr;
    assign o_write_addr = w_res.write_addr;
    assign o_wide = w_res.wide;
    assign o_xfer_channel = w_res.xfer_channel;
    assign o_last = w_res.last;
    assign o_busy_mask = w_res.busy_mask;

    a_xfer_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_transfer_valid) |-> (o_read_addr == '0 && o_last == 1'b0))
        else $error("idle result carries transfer fields");
    a_take_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_valid)
        else $error("engine took from an empty command queue");
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && !w_take) |=> w_valid)
        else $error("accepted item lost in front queue");
endmodule

@@ tb/sv/tb_dma_channel_controller_core.sv @@
// Self-checking testbench for dma_channel_controller_core.
// Depends on dcc_pkg; predicts each result item from a behavioral channel model.
module tb_dma_channel_controller_core;
    import dcc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [2:0] FUNC_QUERY = 3'd4;
    localparam logic [2:0] FUNC_SPARE = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [2:0]  i_func = '0;
    logic [1:0]  i_channel = '0;
    logic [31:0] i_src_addr = '0;
    logic [31:0] i_dst_addr = '0;
    logic [31:0] i_control_word = '0;
    logic [1:0]  i_start_type = '0;
    logic        o_transfer_valid;
    logic [31:0] o_read_addr;
    logic [31:0] o_write_addr;
    logic        o_wide;
    logic [1:0]  o_xfer_channel;
    logic        o_last;
    logic [3:0]  o_busy_mask;

    logic [31:0] src_ptr [NUM_CHANNELS];
    logic [31:0] dst_ptr [NUM_CHANNELS];
    logic [31:0] dst_saved [NUM_CHANNELS];
    logic [16:0] run_len [NUM_CHANNELS];
    logic [16:0] run_left [NUM_CHANNELS];
    logic [15:0] mode [NUM_CHANNELS];
    logic        armed [NUM_CHANNELS];

    t_res expected_items[$];
    int   mismatches = 0;
    int   cycles = 0;
    bit   pop_enable = 1'b1;

    dma_channel_controller_core i_dut (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("dma_channel_controller_core verification failed");
            $finish;
        end
    end

    function automatic logic [3:0] busy_now();
        logic [3:0] m;
        m = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) m[c] = mode[c][M_ENABLE];
        return m;
    endfunction

    function automatic void end_run(int c);
        armed[c] = 1'b0;
        if (mode[c][M_REPEAT]) begin
            if (mode[c][M_DEST_LO+:2] == PMODE_RELOAD) dst_ptr[c] = dst_saved[c];
        end else begin
            mode[c][M_ENABLE] = 1'b0;
        end
    endfunction

    function automatic void start_run(int c);
        if (run_len[c] == 0) begin
            end_run(c);
        end else begin
            run_left[c] = run_len[c];
            armed[c] = 1'b1;
        end
    endfunction

    function automatic logic [31:0] stepped(logic [31:0] p, logic [1:0] pm, logic [31:0] sz);
        if (pm == PMODE_INC || pm == PMODE_RELOAD) return p + sz;
        if (pm == PMODE_DEC) return p - sz;
        return p;
    endfunction

    function automatic t_res predict_item(logic [2:0] fn, logic [1:0] ch, logic [31:0] sa,
                                          logic [31:0] da, logic [31:0] cw, logic [1:0] st);
        t_res r;
        int c;
        logic [31:0] sz;
        logic [1:0] sm;
        bit fin;
        r = '0;
        if (fn == FUNC_PROGRAM) begin
            src_ptr[ch] = sa;
            dst_ptr[ch] = da;
            dst_saved[ch] = da;
            run_len[ch] = cw[16:0];
            run_left[ch] = '0;
            mode[ch] = cw[31:16];
            armed[ch] = 1'b0;
            if (mode[ch][M_ENABLE] && mode[ch][M_TIM_LO+:2] == 2'd0) start_run(ch);
        end else if (fn == FUNC_TRIGGER) begin
            for (c = 0; c < NUM_CHANNELS; c++)
                if (!armed[c] && mode[c][M_ENABLE] && mode[c][M_TIM_LO+:2] == st)
                    start_run(c);
        end else if (fn == FUNC_STOP) begin
            mode[ch][M_ENABLE] = 1'b0;
            mode[ch][M_TIM_LO+:2] = 2'b00;
            mode[ch][M_DREQ] = 1'b0;
            mode[ch][M_REPEAT] = 1'b0;
            armed[ch] = 1'b0;
        end else if (fn == FUNC_ADVANCE) begin
            for (c = 0; c < NUM_CHANNELS; c++) if (armed[c]) break;
            if (c < NUM_CHANNELS) begin
                sz = mode[c][M_WIDE] ? 32'd4 : 32'd2;
                fin = run_left[c] <= 1;
                r.transfer_valid = 1'b1;
                r.read_addr = src_ptr[c];
                r.write_addr = dst_ptr[c];
                r.wide = mode[c][M_WIDE];
                r.xfer_channel = c[1:0];
                r.last = fin;
                dst_ptr[c] = stepped(dst_ptr[c], mode[c][M_DEST_LO+:2], sz);
                sm = mode[c][M_SRC_LO+:2];
                if (sm == 2'd3) sm = 2'd2;
                src_ptr[c] = stepped(src_ptr[c], sm, sz);
                run_left[c] = fin ? 17'd0 : run_left[c] - 17'd1;
                if (fin) end_run(c);
            end
        end
        r.busy_mask = busy_now();
        return r;
    endfunction

    task automatic send_item(logic [2:0] fn, logic [1:0] ch, logic [31:0] sa,
                             logic [31:0] da, logic [31:0] cw, logic [1:0] st);
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_func <= fn;
        i_channel <= ch;
        i_src_addr <= sa;
        i_dst_addr <= da;
        i_control_word <= cw;
        i_start_type <= st;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        expected_items.push_back(predict_item(fn, ch, sa, da, cw, st));
    endtask

    // Pop side: a fresh random stall, possibly none, before each accepted item, and none while pop_enable is clear.
    initial begin
        int wait_n;
        wait (i_rst_n);
        forever begin
            wait_n = pop_enable ? $urandom_range(0, 3) : 0;
            if ($urandom_range(0, 4) == 0) wait_n = 0;
            if (wait_n != 0) begin
                pop <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            check_item();
        end
    end

    task automatic check_item();
        t_res got;
        t_res exp;
        got = {o_transfer_valid, o_read_addr, o_write_addr, o_wide,
               o_xfer_channel, o_last, o_busy_mask};
        if (expected_items.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %h", got);
            return;
        end
        exp = expected_items.pop_front();
        if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected v=%b r=%h w=%h wd=%b ch=%0d l=%b b=%h, ",
                         exp.transfer_valid, exp.read_addr, exp.write_addr, exp.wide,
                         exp.xfer_channel, exp.last, exp.busy_mask,
                         "got v=%b r=%h w=%h wd=%b ch=%0d l=%b b=%h",
                         got.transfer_valid, got.read_addr, got.write_addr, got.wide,
                         got.xfer_channel, got.last, got.busy_mask);
        end
    endtask

    function automatic logic [31:0] random_control(bit enable, logic [1:0] timing, int max_len);
        logic [31:0] cw;
        cw = $urandom;
        cw[16:0] = 17'($urandom_range(0, max_len));
        cw[31] = enable;
        cw[29:28] = timing;
        return cw;
    endfunction

    task automatic test_directed();
        send_item(FUNC_QUERY, 0, 0, 0, 0, 0);
        send_item(FUNC_ADVANCE, 0, 0, 0, 0, 0);
        // Full-range count with wrapping addresses, increment on both sides.
        send_item(FUNC_PROGRAM, 0, 32'hffff_fffe, 32'hffff_fffc, 32'h8401_ffff, 0);
        repeat (3) send_item(FUNC_ADVANCE, 0, 0, 0, 0, 0);
        send_item(FUNC_STOP, 0, 0, 0, 0, 0);
        // Zero count with repeat and reload keeps the channel enabled.
        send_item(FUNC_PROGRAM, 1, 32'h10, 32'h20, 32'h8260_0000, 0);
        // Zero count without repeat disables the channel.
        send_item(FUNC_PROGRAM, 2, 0, 0, 32'h8000_0000, 0);
        // Decrement and fixed modes, repeat with reload, on a start-type 3 trigger.
        send_item(FUNC_PROGRAM, 3, 32'h100, 32'h200, 32'hb2e0_0002, 0);
        send_item(FUNC_TRIGGER, 0, 0, 0, 0, 2'd1);
        send_item(FUNC_TRIGGER, 0, 0, 0, 0, 2'd1);
        repeat (3) send_item(FUNC_ADVANCE, 0, 0, 0, 0, 0);
        send_item(FUNC_TRIGGER, 0, 0, 0, 0, 2'd1);
        send_item(FUNC_PROGRAM, 3, 32'h300, 32'h400, 32'hbfa0_0003, 0);
        send_item(FUNC_TRIGGER, 0, 0, 0, 0, 2'd3);
        send_item(FUNC_ADVANCE, 0, 0, 0, 0, 0);
        send_item(FUNC_STOP, 3, 0, 0, 0, 0);
        send_item(FUNC_ADVANCE, 0, 0, 0, 0, 0);
        send_item(FUNC_SPARE, 3, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 3);
        send_item(3'd5, 0, 0, 0, 0, 0);
        send_item(3'd6, 0, 0, 0, 0, 0);
        send_item(FUNC_PROGRAM, 0, 0, 0, 32'h2000_0001, 0);
    endtask

    task automatic test_random(int n);
        int k;
        int r;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 15)
                send_item(FUNC_PROGRAM, 2'($urandom), $urandom, $urandom,
                          random_control($urandom_range(0, 7) != 0, 2'($urandom),
                                         ($urandom_range(0, 20) == 0) ? 'h1ffff : 6), 2'd0);
            else if (r < 27)
                send_item(FUNC_TRIGGER, 2'($urandom), $urandom, $urandom, $urandom,
                          2'($urandom));
            else if (r < 31)
                send_item(FUNC_STOP, 2'($urandom), $urandom, $urandom, $urandom,
                          2'($urandom));
            else if (r < 92)
                send_item(FUNC_ADVANCE, 2'($urandom), $urandom, $urandom, $urandom,
                          2'($urandom));
            else
                send_item(3'($urandom_range(4, 7)), 2'($urandom), $urandom, $urandom,
                          $urandom, 2'($urandom));
        end
    endtask

    initial begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            src_ptr[c] = '0; dst_ptr[c] = '0; dst_saved[c] = '0;
            run_len[c] = '0; run_left[c] = '0; mode[c] = '0; armed[c] = 1'b0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(700);
        pop_enable = 1'b0;
        test_random(400);
        pop_enable = 1'b1;
        test_random(430);
        push <= 1'b0;
        while (expected_items.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("dma_channel_controller_core verification clean");
        else
            $display("dma_channel_controller_core verification failed");
        $finish;
    end
endmodule

@@ files.f @@
design/dcc_pkg.sv
design/dcc_front.sv
design/dcc_engine.sv
design/dma_channel_controller_core.sv
tb/sv/tb_dma_channel_controller_core.sv
